// File: hdl/stick_to_wheel_scroll_defines.svh
// ----------------------------------------------------------------------------
// stick_to_wheel_scroll_defines.svh
// Assertion macros for the stick to wheel scroll block.
// ----------------------------------------------------------------------------
`ifndef STICK_TO_WHEEL_SCROLL_DEFINES_SVH
`define STICK_TO_WHEEL_SCROLL_DEFINES_SVH

`ifndef SYNTHESIS
`define STWS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define STWS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define STWS_ASSERT(lbl, prop, msg)
`define STWS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: hdl/stws_pkg.sv
// ----------------------------------------------------------------------------
// stws_pkg
// Types, register map, microcode ROM and dispatch for the wheel scroll block.
// ----------------------------------------------------------------------------
package stws_pkg;

	localparam int FRAC_BITS_DEF = 15;

	localparam logic [1:0] ACT_AXIS  = 2'd0;
	localparam logic [1:0] ACT_FRAME = 2'd1;
	localparam logic [1:0] ACT_CTX   = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [2:0] AXIS_LX = 3'd0;
	localparam logic [2:0] AXIS_LY = 3'd1;

	localparam logic [1:0] REG_DEADZONE  = 2'd0;
	localparam logic [1:0] REG_RANGE     = 2'd1;
	localparam logic [1:0] REG_GAIN      = 2'd2;
	localparam logic [1:0] REG_MAX_STEPS = 2'd3;

	localparam logic [14:0] DEADZONE_RST  = 15'd7209;
	localparam logic [15:0] RANGE_RST     = 16'd21005;
	localparam logic [15:0] GAIN_RST      = 16'd24576;
	localparam logic [2:0]  MAX_STEPS_RST = 3'd3;

	typedef struct packed {
		logic [14:0] deadzone;
		logic [15:0] range_scale;
		logic [15:0] scroll_gain;
		logic [2:0]  max_steps;
	} cfg_t;

	// datapath operations
	localparam logic [3:0] OP_NOP    = 4'd0;
	localparam logic [3:0] OP_AXIS   = 4'd1;
	localparam logic [3:0] OP_CTX    = 4'd2;
	localparam logic [3:0] OP_CLR    = 4'd3;
	localparam logic [3:0] OP_MULX   = 4'd4;
	localparam logic [3:0] OP_NX     = 4'd5;
	localparam logic [3:0] OP_NY     = 4'd6;
	localparam logic [3:0] OP_MULW   = 4'd7;
	localparam logic [3:0] OP_MULG   = 4'd8;
	localparam logic [3:0] OP_ACC    = 4'd9;
	localparam logic [3:0] OP_EMIT   = 4'd10;
	localparam logic [3:0] OP_CLRACC = 4'd11;

	localparam logic [1:0] CND_NONE   = 2'd0;
	localparam logic [1:0] CND_GATED  = 2'd1;
	localparam logic [1:0] CND_NYZERO = 2'd2;

	localparam int STEP_W = 4;

	localparam logic [STEP_W-1:0] ST_AXIS   = 4'd0;
	localparam logic [STEP_W-1:0] ST_CTX    = 4'd1;
	localparam logic [STEP_W-1:0] ST_CLR    = 4'd2;
	localparam logic [STEP_W-1:0] ST_FRAME  = 4'd3;
	localparam logic [STEP_W-1:0] ST_NX     = 4'd4;
	localparam logic [STEP_W-1:0] ST_NY     = 4'd5;
	localparam logic [STEP_W-1:0] ST_MULW   = 4'd6;
	localparam logic [STEP_W-1:0] ST_MULG   = 4'd7;
	localparam logic [STEP_W-1:0] ST_ACC    = 4'd8;
	localparam logic [STEP_W-1:0] ST_EMIT   = 4'd9;
	localparam logic [STEP_W-1:0] ST_CLRACC = 4'd10;
	localparam logic [STEP_W-1:0] ST_DONE   = 4'd11;

	typedef struct packed {
		logic [3:0]        op;
		logic [1:0]        cond;
		logic [STEP_W-1:0] tgt;
		logic              last;
	} ctl_t;

	typedef struct packed {
		logic gated;
		logic ny_zero;
		logic out_busy;
	} stat_t;

	function automatic ctl_t ucode_rom(input logic [STEP_W-1:0] step);
		ctl_t w;
		w = '{op: OP_NOP, cond: CND_NONE, tgt: ST_DONE, last: 1'b1};
		case (step)
			ST_AXIS:   w = '{op: OP_AXIS,   cond: CND_NONE,   tgt: ST_DONE,   last: 1'b1};
			ST_CTX:    w = '{op: OP_CTX,    cond: CND_NONE,   tgt: ST_DONE,   last: 1'b1};
			ST_CLR:    w = '{op: OP_CLR,    cond: CND_NONE,   tgt: ST_DONE,   last: 1'b1};
			ST_FRAME:  w = '{op: OP_MULX,   cond: CND_GATED,  tgt: ST_DONE,   last: 1'b0};
			ST_NX:     w = '{op: OP_NX,     cond: CND_NONE,   tgt: ST_DONE,   last: 1'b0};
			ST_NY:     w = '{op: OP_NY,     cond: CND_NYZERO, tgt: ST_CLRACC, last: 1'b0};
			ST_MULW:   w = '{op: OP_MULW,   cond: CND_NONE,   tgt: ST_DONE,   last: 1'b0};
			ST_MULG:   w = '{op: OP_MULG,   cond: CND_NONE,   tgt: ST_DONE,   last: 1'b0};
			ST_ACC:    w = '{op: OP_ACC,    cond: CND_NONE,   tgt: ST_DONE,   last: 1'b0};
			ST_EMIT:   w = '{op: OP_EMIT,   cond: CND_NONE,   tgt: ST_DONE,   last: 1'b1};
			ST_CLRACC: w = '{op: OP_CLRACC, cond: CND_NONE,   tgt: ST_DONE,   last: 1'b1};
			ST_DONE:   w = '{op: OP_NOP,    cond: CND_NONE,   tgt: ST_DONE,   last: 1'b1};
			default:   w = '{op: OP_NOP,    cond: CND_NONE,   tgt: ST_DONE,   last: 1'b1};
		endcase
		return w;
	endfunction

	function automatic logic [STEP_W-1:0] entry_step(input logic [1:0] action);
		logic [STEP_W-1:0] s;
		case (action)
			ACT_AXIS:  s = ST_AXIS;
			ACT_FRAME: s = ST_FRAME;
			ACT_CTX:   s = ST_CTX;
			ACT_CLEAR: s = ST_CLR;
			default:   s = ST_DONE;
		endcase
		return s;
	endfunction

endpackage

// File: hdl/stws_regs.sv
// ----------------------------------------------------------------------------
// stws_regs
// APB register file: deadzone, range scale, gain, max steps.
// ----------------------------------------------------------------------------
module stws_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output stws_pkg::cfg_t     cfg
);

	stws_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone    <= stws_pkg::DEADZONE_RST;
			cfg_q.range_scale <= stws_pkg::RANGE_RST;
			cfg_q.scroll_gain <= stws_pkg::GAIN_RST;
			cfg_q.max_steps   <= stws_pkg::MAX_STEPS_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				stws_pkg::REG_DEADZONE:  cfg_q.deadzone    <= pwdata[14:0];
				stws_pkg::REG_RANGE:     cfg_q.range_scale <= pwdata[15:0];
				stws_pkg::REG_GAIN:      cfg_q.scroll_gain <= pwdata[15:0];
				stws_pkg::REG_MAX_STEPS: cfg_q.max_steps   <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			stws_pkg::REG_DEADZONE:  prdata = {17'd0, cfg_q.deadzone};
			stws_pkg::REG_RANGE:     prdata = {16'd0, cfg_q.range_scale};
			stws_pkg::REG_GAIN:      prdata = {16'd0, cfg_q.scroll_gain};
			stws_pkg::REG_MAX_STEPS: prdata = {29'd0, cfg_q.max_steps};
			default:                 prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/stws_seq.sv
// ----------------------------------------------------------------------------
// stws_seq
// Microcode sequencer: step counter, ROM lookup, conditional jumps.
// ----------------------------------------------------------------------------
module stws_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           action,
	input  stws_pkg::stat_t      stat,
	output logic                 busy,
	output stws_pkg::ctl_t       ctl
);

	logic                          busy_q;
	logic [stws_pkg::STEP_W-1:0]   step_q;
	stws_pkg::ctl_t                word;
	logic                          hold;
	logic                          jump;

	assign word = stws_pkg::ucode_rom(step_q);

	// emit waits while the output word is still held
	assign hold = busy_q & (word.op == stws_pkg::OP_EMIT) & stat.out_busy;

	always_comb begin
		case (word.cond)
			stws_pkg::CND_GATED:  jump = stat.gated;
			stws_pkg::CND_NYZERO: jump = stat.ny_zero;
			default:              jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= stws_pkg::ST_DONE;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= stws_pkg::entry_step(action);
		end else if (busy_q && !hold) begin
			if (jump) begin
				step_q <= word.tgt;
			end else if (word.last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_comb begin
		ctl = word;
		if (!busy_q || hold) begin
			ctl.op = stws_pkg::OP_NOP;
		end
	end

	assign busy = busy_q;

endmodule

// File: hdl/stws_dp.sv
// ----------------------------------------------------------------------------
// stws_dp
// Datapath: stick registers, shared multiplier, accumulator, output word.
// ----------------------------------------------------------------------------
module stws_dp #(
	parameter int FRAC_BITS = stws_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            axis_id,
	input  logic signed [15:0]    axis_raw,
	input  logic                  in_ui,
	input  logic                  device_is_gamepad,
	input  logic                  device_switched,
	input  stws_pkg::cfg_t        cfg,
	input  stws_pkg::ctl_t        ctl,
	input  logic                  out_stall,
	output stws_pkg::stat_t       stat,
	output logic                  out_valid,
	output logic signed [3:0]     step_count
);

	localparam int ACC_W = FRAC_BITS + 5;
	localparam int SUM_W = FRAC_BITS + 6;
	localparam int SHR   = 30 - FRAC_BITS;
	localparam logic signed [SUM_W-1:0] LIM = SUM_W'((1 << (FRAC_BITS + 4)) - 1);

	logic [2:0]               axis_id_q;
	logic signed [15:0]       raw_q;
	logic                     in_ui_q;
	logic                     gamepad_q;
	logic                     switched_q;

	logic signed [15:0]       stick_x_q;
	logic signed [15:0]       stick_y_q;
	logic signed [ACC_W-1:0]  res_q;
	logic [31:0]              prod_q;
	logic [14:0]              nx_q;
	logic [14:0]              ny_q;
	logic                     out_valid_q;
	logic signed [3:0]        wheel_q;

	logic [14:0]              mag_x, mag_y, diff_x, diff_y, norm_sat;
	logic                     zero_x, zero_y;
	logic [15:0]              mul_a, mul_b;
	logic                     mul_en;
	logic [15:0]              wgt;
	logic [31:0]              s_shift;
	logic signed [SUM_W-1:0]  s_mag, strength, sum, sum_sat;
	logic                     res_neg;
	logic [ACC_W-1:0]         res_mag;
	logic [3:0]               whole, whole_c;
	logic [ACC_W-1:0]         step_amt;
	logic                     emit_fire;
	logic signed [15:0]       raw_clamped;

	function automatic logic [14:0] abs15(input logic signed [15:0] v);
		logic signed [15:0] n;
		n = -v;
		return v[15] ? n[14:0] : v[14:0];
	endfunction

	assign mag_x    = abs15(stick_x_q);
	assign mag_y    = abs15(stick_y_q);
	assign zero_x   = mag_x <= cfg.deadzone;
	assign zero_y   = mag_y <= cfg.deadzone;
	assign diff_x   = mag_x - cfg.deadzone;
	assign diff_y   = mag_y - cfg.deadzone;
	assign norm_sat = (|prod_q[31:29]) ? 15'h7fff : prod_q[28:14];
	assign wgt      = 16'h8000 - {1'b0, nx_q};

	always_comb begin
		mul_en = 1'b1;
		mul_a  = 16'd0;
		mul_b  = 16'd0;
		case (ctl.op)
			stws_pkg::OP_MULX: begin
				mul_a = {1'b0, diff_x};
				mul_b = cfg.range_scale;
			end
			stws_pkg::OP_NX: begin
				mul_a = {1'b0, diff_y};
				mul_b = cfg.range_scale;
			end
			stws_pkg::OP_MULW: begin
				mul_a = {1'b0, ny_q};
				mul_b = wgt;
			end
			stws_pkg::OP_MULG: begin
				mul_a = prod_q[30:15];
				mul_b = cfg.scroll_gain;
			end
			default: mul_en = 1'b0;
		endcase
	end

	// strength, sign opposite to Y
	assign s_shift  = prod_q >> SHR;
	assign s_mag    = s_shift[SUM_W-1:0];
	assign strength = stick_y_q[15] ? s_mag : -s_mag;
	assign sum      = {res_q[ACC_W-1], res_q} + strength;

	always_comb begin
		if (sum > LIM) begin
			sum_sat = LIM;
		end else if (sum < -LIM) begin
			sum_sat = -LIM;
		end else begin
			sum_sat = sum;
		end
	end

	assign res_neg  = res_q[ACC_W-1];
	assign res_mag  = res_neg ? ACC_W'(-res_q) : ACC_W'(res_q);
	assign whole    = res_mag[FRAC_BITS+3:FRAC_BITS];
	assign whole_c  = (whole > {1'b0, cfg.max_steps}) ? {1'b0, cfg.max_steps} : whole;
	assign step_amt = ACC_W'(whole_c) << FRAC_BITS;
	assign emit_fire = (ctl.op == stws_pkg::OP_EMIT) && (whole_c != 4'd0);

	assign raw_clamped = (raw_q == 16'sh8000) ? -16'sd32767 : raw_q;

	always_ff @(posedge clk) begin
		if (start) begin
			axis_id_q  <= axis_id;
			raw_q      <= axis_raw;
			in_ui_q    <= in_ui;
			gamepad_q  <= device_is_gamepad;
			switched_q <= device_switched;
		end
		if (mul_en) begin
			prod_q <= {16'd0, mul_a} * {16'd0, mul_b};
		end
		if (ctl.op == stws_pkg::OP_NX) begin
			nx_q <= zero_x ? 15'd0 : norm_sat;
		end
		if (ctl.op == stws_pkg::OP_NY) begin
			ny_q <= zero_y ? 15'd0 : norm_sat;
		end
		if (emit_fire) begin
			wheel_q <= res_neg ? -$signed(whole_c) : $signed(whole_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_x_q <= '0;
			stick_y_q <= '0;
			res_q     <= '0;
		end else begin
			case (ctl.op)
				stws_pkg::OP_AXIS: begin
					if (axis_id_q == stws_pkg::AXIS_LX) begin
						stick_x_q <= raw_clamped;
					end else if (axis_id_q == stws_pkg::AXIS_LY) begin
						stick_y_q <= raw_clamped;
					end
				end
				stws_pkg::OP_CTX: begin
					if (!in_ui_q) begin
						res_q <= '0;
					end
				end
				stws_pkg::OP_CLR: begin
					stick_x_q <= '0;
					stick_y_q <= '0;
					res_q     <= '0;
				end
				stws_pkg::OP_ACC:    res_q <= sum_sat[ACC_W-1:0];
				stws_pkg::OP_EMIT: begin
					if (emit_fire) begin
						res_q <= res_neg ? res_q + $signed(step_amt)
						                 : res_q - $signed(step_amt);
					end
				end
				stws_pkg::OP_CLRACC: res_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.gated    = !in_ui_q | !gamepad_q | switched_q;
	assign stat.ny_zero  = zero_y | (norm_sat == 15'd0);
	assign stat.out_busy = out_valid_q & out_stall;

	assign out_valid  = out_valid_q;
	assign step_count = wheel_q;

endmodule

// File: hdl/stick_to_wheel_scroll.sv
// ----------------------------------------------------------------------------
// stick_to_wheel_scroll
// Analog stick to mouse wheel steps, run by a microcoded sequencer.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  action, axis_id, axis_raw, in_ui,
//                                 device_is_gamepad, device_switched
//   out      out_valid/ out_stall step_count
//   cfg      APB write/read       deadzone, range_scale, scroll_gain, max_steps
//
// A gated frame jumps to done from its first step; a frame with zero Y clears
// the accumulator after NY. A full frame runs MULX to EMIT on the one shared
// 16x16 multiplier used in four steps. Emit waits while the output word is
// stalled; the next input word is taken the cycle after the last step.
// Reset restores register defaults and clears sticks and accumulator.
// ----------------------------------------------------------------------------
`include "stick_to_wheel_scroll_defines.svh"

module stick_to_wheel_scroll #(
	parameter int FRAC_BITS = stws_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [2:0]         axis_id,
	input  logic signed [15:0] axis_raw,
	input  logic               in_ui,
	input  logic               device_is_gamepad,
	input  logic               device_switched,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [3:0]  step_count,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	stws_pkg::cfg_t  cfg;
	stws_pkg::ctl_t  ctl;
	stws_pkg::stat_t stat;
	logic            busy;
	logic            start;

	assign start    = in_valid & ~busy;
	assign in_stall = busy;
	assign pready   = 1'b1;

	stws_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	stws_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	stws_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.axis_id           (axis_id),
		.axis_raw          (axis_raw),
		.in_ui             (in_ui),
		.device_is_gamepad (device_is_gamepad),
		.device_switched   (device_switched),
		.cfg               (cfg),
		.ctl               (ctl),
		.out_stall         (out_stall),
		.stat              (stat),
		.out_valid         (out_valid),
		.step_count        (step_count)
	);

	`STWS_ASSERT(a_busy_after_accept, start |=> busy, "sequencer not busy after accept")
	`STWS_ASSERT_NEVER(a_no_zero_step, out_valid && (step_count == 4'sd0), "zero step emitted")
	`STWS_ASSERT(a_emit_from_busy, $rose(out_valid) |-> $past(busy), "word emitted while idle")

endmodule
